@@ sv/half_float_texture_packer_assert.svh @@
// Assertion macros for the half float texture packer.
`ifndef HALF_FLOAT_TEXTURE_PACKER_ASSERT_SVH
`define HALF_FLOAT_TEXTURE_PACKER_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define HFTP_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define HFTP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/hftp_pkg.sv @@
package hftp_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgHarmonicDim   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgTextureWidth  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTextureHeight = 2'd2;

  localparam logic [15:0] HalfOne = 16'h3C00;
  localparam int unsigned NumLanes = 3;

  typedef struct packed {
    logic [23:0] vertex_index;
    logic [3:0]  component_index;
  } addr_req_t;

endpackage

@@ sv/half_float_texture_packer.sv @@
// Channel   | Direction | Payload
// s_axis    | in        | vertex, component, x, y, z singles
// m_axis    | out       | address, packed xy, packed z and one, in range flag
// cfg       | in        | register index and write data
// One word is accepted per cycle while s_axis_tready is high.
// The result passes through the merge register, then an output register; the conversion lanes are combinational.
// Reset clears the valid flags and sets harmonic_dim, width and height to one.
// A stall holds the output word, and the input stage keeps moving while it can.
module half_float_texture_packer import hftp_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // vertex_index[23:0], component_index[27:24], x[59:28], y[91:60], z[123:92]
  input  logic [127:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // word_address[31:0], packed_xy[63:32], packed_z_one[95:64]
  output logic [95:0]  m_axis_tdata,
  // in_range[0]
  output logic         m_axis_tuser,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]  cfg_data_i
);

  `include "half_float_texture_packer_assert.svh"

  logic [4:0]  dim_q;
  logic [12:0] width_q, height_q;
  logic [15:0] half [NumLanes];
  logic        mid_valid_q, out_valid_q;
  logic        mid_en, out_en;
  logic [31:0] m_addr, m_xy, m_z;
  logic        m_rng;
  logic [96:0] out_q;
  addr_req_t   req;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_q    <= 5'd1;
      width_q  <= 13'd1;
      height_q <= 13'd1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHarmonicDim:   dim_q    <= cfg_data_i[4:0];
        CfgTextureWidth:  width_q  <= cfg_data_i[12:0];
        CfgTextureHeight: height_q <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  for (genvar l = 0; l < NumLanes; l++) begin : g_lane
    hftp_lane u_lane (
      .single_i(s_axis_tdata[28 + 32*l +: 32]),
      .half_o  (half[l])
    );
  end

  assign req.vertex_index    = s_axis_tdata[23:0];
  assign req.component_index = s_axis_tdata[27:24];

  assign out_en        = !out_valid_q || m_axis_tready;
  assign mid_en        = !mid_valid_q || out_en;
  assign s_axis_tready = mid_en;

  hftp_merge u_merge (
    .clk_i, .rst_ni,
    .en_i            (mid_en && s_axis_tvalid),
    .req_i           (req),
    .harmonic_dim_i  (dim_q),
    .texture_width_i (width_q),
    .texture_height_i(height_q),
    .half_x_i        (half[0]),
    .half_y_i        (half[1]),
    .half_z_i        (half[2]),
    .word_address_o  (m_addr),
    .packed_xy_o     (m_xy),
    .packed_z_one_o  (m_z),
    .in_range_o      (m_rng)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (mid_en) mid_valid_q <= s_axis_tvalid;
      if (out_en) out_valid_q <= mid_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && mid_valid_q) out_q <= {m_rng, m_z, m_xy, m_addr};
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q[95:0];
  assign m_axis_tuser  = out_q[96];

  `HFTP_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `HFTP_ASSERT_IMPL(a_one_half, m_axis_tvalid, m_axis_tdata[95:80] == HalfOne)
  `HFTP_ASSERT_NEXT(a_mid_move, mid_valid_q && out_en, out_valid_q)

endmodule

@@ sv/hftp_lane.sv @@
module hftp_lane import hftp_pkg::*; (
  input  logic [31:0] single_i,
  output logic [15:0] half_o
);

  logic       sign;
  logic [7:0] expo;
  logic [22:0] mant;
  logic [7:0] shift;
  logic [23:0] full_mant;
  logic [23:0] den;
  logic [4:0] hexp;
  logic [9:0] hman;

  assign sign      = single_i[31];
  assign expo      = single_i[30:23];
  assign mant      = single_i[22:0];
  assign shift     = 8'd126 - expo;
  assign full_mant = {1'b1, mant};
  assign den       = (shift >= 8'd32) ? 24'd0 : (full_mant >> shift[4:0]);

  always_comb begin
    if (expo == 8'd0) begin
      hexp = 5'd0;
      hman = 10'd0;
    end else if (expo < 8'd113) begin
      hexp = 5'd0;
      hman = den[9:0];
    end else if (expo <= 8'd142) begin
      hexp = 5'(expo - 8'd112);
      hman = mant[22:13];
    end else begin
      hexp = 5'd31;
      hman = 10'd0;
    end
  end

  assign half_o = {sign, hexp, hman};

endmodule

@@ sv/hftp_merge.sv @@
module hftp_merge import hftp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  addr_req_t  req_i,
  input  logic [4:0] harmonic_dim_i,
  input  logic [12:0] texture_width_i,
  input  logic [12:0] texture_height_i,
  input  logic [15:0] half_x_i,
  input  logic [15:0] half_y_i,
  input  logic [15:0] half_z_i,
  output logic [31:0] word_address_o,
  output logic [31:0] packed_xy_o,
  output logic [31:0] packed_z_one_o,
  output logic        in_range_o
);

  logic [4:0]  tpv;
  logic [33:0] addr;
  logic [27:0] words;
  logic [33:0] addr_q, addr_d;
  logic [27:0] words_q, words_d;
  logic        comp_ok_q, comp_ok_d;
  logic [31:0] xy_q, z_q;

  assign tpv     = 5'((6'(harmonic_dim_i) + 6'd1) >> 1);
  assign addr    = 34'({tpv, 2'b00}) * 34'(req_i.vertex_index)
                 + 34'({req_i.component_index, 1'b0});
  assign words   = {2'b00, (26'(texture_width_i) * 26'(texture_height_i))} << 2;
  assign addr_d  = addr;
  assign words_d = words;
  assign comp_ok_d = 5'(req_i.component_index) < harmonic_dim_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comp_ok_q <= 1'b0;
    end else if (en_i) begin
      comp_ok_q <= comp_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      addr_q  <= addr_d;
      words_q <= words_d;
      xy_q    <= {half_y_i, half_x_i};
      z_q     <= {HalfOne, half_z_i};
    end
  end

  assign word_address_o = addr_q[31:0];
  assign packed_xy_o    = xy_q;
  assign packed_z_one_o = z_q;
  assign in_range_o     = comp_ok_q && ((addr_q + 34'd1) < 34'(words_q));

endmodule
